@@ sv/calculator_token_scanner_macros.svh @@
// assertion macros used by the checker file
`ifndef CALCULATOR_TOKEN_SCANNER_MACROS_SVH
`define CALCULATOR_TOKEN_SCANNER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while in reset
`define CTS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("token scanner check failed");

// next-cycle implication, clocked on i_clk, off while in reset
`define CTS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("token scanner check failed");

`endif

@@ sv/cts_pkg.sv @@
// package: types, codes and constants of the calculator token scanner
`default_nettype none

package cts_pkg;

    localparam int LINE_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CHAR_W     = 8;
    localparam int KIND_W     = 4;
    localparam int ERR_W      = 2;
    localparam int LINE_NUM_W = 16;
    localparam int KW_W       = 4;

    localparam logic [KIND_W-1:0] KIND_ID      = 4'd0;
    localparam logic [KIND_W-1:0] KIND_LIT     = 4'd1;
    localparam logic [KIND_W-1:0] KIND_READ    = 4'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_BECOMES = 4'd4;
    localparam logic [KIND_W-1:0] KIND_LPAREN  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_RPAREN  = 4'd6;
    localparam logic [KIND_W-1:0] KIND_ADD     = 4'd7;
    localparam logic [KIND_W-1:0] KIND_SUB     = 4'd8;
    localparam logic [KIND_W-1:0] KIND_MUL     = 4'd9;
    localparam logic [KIND_W-1:0] KIND_DIV     = 4'd10;
    localparam logic [KIND_W-1:0] KIND_EOF     = 4'd11;

    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAD_ASSIGN = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OPEN_CMT   = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_CHAR   = 2'd3;

    localparam logic [KW_W-1:0] KW_NONE  = 4'd0;
    localparam logic [KW_W-1:0] KW_R1    = 4'd1;
    localparam logic [KW_W-1:0] KW_R2    = 4'd2;
    localparam logic [KW_W-1:0] KW_R3    = 4'd3;
    localparam logic [KW_W-1:0] KW_READ  = 4'd4;
    localparam logic [KW_W-1:0] KW_W1    = 4'd5;
    localparam logic [KW_W-1:0] KW_W2    = 4'd6;
    localparam logic [KW_W-1:0] KW_W3    = 4'd7;
    localparam logic [KW_W-1:0] KW_W4    = 4'd8;
    localparam logic [KW_W-1:0] KW_WRITE = 4'd9;

    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_0      = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9      = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_D   = 8'h64;
    localparam logic [CHAR_W-1:0] CH_LO_E   = 8'h65;
    localparam logic [CHAR_W-1:0] CH_LO_I   = 8'h69;
    localparam logic [CHAR_W-1:0] CH_LO_R   = 8'h72;
    localparam logic [CHAR_W-1:0] CH_LO_T   = 8'h74;
    localparam logic [CHAR_W-1:0] CH_LO_W   = 8'h77;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_COLON,
        MODE_SLASH,
        MODE_LINEC,
        MODE_BLOCKC
    } t_mode;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ERR_W-1:0]  err;
    } t_result;

    // results of one input beat: one or two, all on the same line
    typedef struct packed {
        logic                  two;
        t_result               res0;
        t_result               res1;
        logic [LINE_NUM_W-1:0] line;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

endpackage

`default_nettype wire

@@ sv/cts_in_if.sv @@
// character channel interface
`default_nettype none

interface cts_in_if;
    import cts_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              end_of_input;

    modport source (output valid, output char_code, output end_of_input, input ready);
    modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface

`default_nettype wire

@@ sv/cts_out_if.sv @@
// token channel interface
`default_nettype none

interface cts_out_if;
    import cts_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     token_kind;
    logic [LINE_NUM_W-1:0] token_line;
    logic [ERR_W-1:0]      error_code;
    logic                  last_of_run;

    modport source (
        output valid, output token_kind, output token_line, output error_code,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input token_line, input error_code,
        input last_of_run, output ready
    );
endinterface

`default_nettype wire

@@ sv/cts_front.sv @@
// front end: accepts characters, runs the scan state machine, builds result entries
`default_nettype none

module cts_front #(
    parameter int LINE_BITS = cts_pkg::LINE_BITS_DEF
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    cts_in_if.sink        i_in,
    input  wire           i_q_full,
    output cts_pkg::t_push o_push
);
    import cts_pkg::*;

    typedef struct packed {
        logic              emit;
        t_result           res;
        t_mode             mode;
        logic [KW_W-1:0]   kw;
        logic              bump;
        logic              halt;
    } t_start;

    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    t_mode                r_mode, n_mode;
    logic [KW_W-1:0]      r_kw, n_kw;
    logic [LINE_BITS-1:0] r_line, n_line;
    logic                 r_star, n_star;
    logic                 r_halt, n_halt;

    logic [CHAR_W-1:0] c;
    logic              eoi;
    logic              fire;
    logic              is_sp, is_al, is_dg, is_idc;
    logic              pre_emit, do_start, bump;
    t_result           pre_res;
    t_start            st;

    function automatic logic [KW_W-1:0] kw_next(input logic [KW_W-1:0] p,
                                                input logic [CHAR_W-1:0] ch);
        logic [KW_W-1:0] q;
        q = KW_NONE;
        case (p)
            KW_R1:   q = (ch == CH_LO_E) ? KW_R2 : KW_NONE;
            KW_R2:   q = (ch == CH_LO_A) ? KW_R3 : KW_NONE;
            KW_R3:   q = (ch == CH_LO_D) ? KW_READ : KW_NONE;
            KW_W1:   q = (ch == CH_LO_R) ? KW_W2 : KW_NONE;
            KW_W2:   q = (ch == CH_LO_I) ? KW_W3 : KW_NONE;
            KW_W3:   q = (ch == CH_LO_T) ? KW_W4 : KW_NONE;
            KW_W4:   q = (ch == CH_LO_E) ? KW_WRITE : KW_NONE;
            default: q = KW_NONE;
        endcase
        return q;
    endfunction

    function automatic t_start start_token(input logic [CHAR_W-1:0] ch, input logic e,
                                           input logic sp, input logic al, input logic dg);
        t_start s;
        s = '0;
        s.mode = MODE_IDLE;
        s.kw   = KW_NONE;
        s.res  = '{kind: KIND_ID, err: ERR_NONE};
        if (e) begin
            s.emit     = 1'b1;
            s.res.kind = KIND_EOF;
        end else if (sp) begin
            s.bump = (ch == CH_LF);
        end else if (al) begin
            s.mode = MODE_IDENT;
            s.kw   = (ch == CH_LO_R) ? KW_R1 : ((ch == CH_LO_W) ? KW_W1 : KW_NONE);
        end else if (dg) begin
            s.mode = MODE_NUMBER;
        end else begin
            case (ch)
                CH_COLON:  s.mode = MODE_COLON;
                CH_SLASH:  s.mode = MODE_SLASH;
                CH_PLUS:   begin s.emit = 1'b1; s.res.kind = KIND_ADD; end
                CH_MINUS:  begin s.emit = 1'b1; s.res.kind = KIND_SUB; end
                CH_STAR:   begin s.emit = 1'b1; s.res.kind = KIND_MUL; end
                CH_LPAREN: begin s.emit = 1'b1; s.res.kind = KIND_LPAREN; end
                CH_RPAREN: begin s.emit = 1'b1; s.res.kind = KIND_RPAREN; end
                default: begin
                    s.emit    = 1'b1;
                    s.res.err = ERR_BAD_CHAR;
                    s.halt    = 1'b1;
                end
            endcase
        end
        return s;
    endfunction

    assign c   = i_in.char_code;
    assign eoi = i_in.end_of_input;

    assign i_in.ready = !i_q_full;
    assign fire       = i_in.valid && !i_q_full && !r_halt;

    assign is_sp  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    assign is_al  = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    assign is_dg  = (c >= CH_0 && c <= CH_9);
    assign is_idc = is_al || is_dg || (c == CH_UNDER);

    assign st = start_token(c, eoi, is_sp, is_al, is_dg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_kw   <= KW_NONE;
            r_line <= LINE_ONE;
            r_star <= 1'b0;
            r_halt <= 1'b0;
        end else if (fire) begin
            r_mode <= n_mode;
            r_kw   <= n_kw;
            r_line <= n_line;
            r_star <= n_star;
            r_halt <= n_halt;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_kw     = r_kw;
        n_star   = r_star;
        n_halt   = r_halt;
        pre_emit = 1'b0;
        pre_res  = '{kind: KIND_ID, err: ERR_NONE};
        do_start = 1'b0;
        bump     = 1'b0;

        case (r_mode)
            MODE_IDENT: begin
                if (!eoi && is_idc) begin
                    n_kw = kw_next(r_kw, c);
                end else begin
                    pre_emit     = 1'b1;
                    pre_res.kind = (r_kw == KW_READ) ? KIND_READ :
                                   ((r_kw == KW_WRITE) ? KIND_WRITE : KIND_ID);
                    do_start     = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (eoi || !is_dg) begin
                    pre_emit     = 1'b1;
                    pre_res.kind = KIND_LIT;
                    do_start     = 1'b1;
                end
            end
            MODE_COLON: begin
                pre_emit = 1'b1;
                n_mode   = MODE_IDLE;
                if (!eoi && c == CH_EQUAL) begin
                    pre_res.kind = KIND_BECOMES;
                end else begin
                    pre_res.err = ERR_BAD_ASSIGN;
                    n_halt      = 1'b1;
                end
            end
            MODE_SLASH: begin
                if (!eoi && c == CH_SLASH) begin
                    n_mode = MODE_LINEC;
                end else if (!eoi && c == CH_STAR) begin
                    n_mode = MODE_BLOCKC;
                    n_star = 1'b0;
                end else begin
                    pre_emit     = 1'b1;
                    pre_res.kind = KIND_DIV;
                    do_start     = 1'b1;
                end
            end
            MODE_LINEC: begin
                do_start = eoi || (c == CH_LF);
            end
            MODE_BLOCKC: begin
                if (eoi) begin
                    pre_emit    = 1'b1;
                    pre_res.err = ERR_OPEN_CMT;
                    n_halt      = 1'b1;
                    n_mode      = MODE_IDLE;
                end else if (r_star && c == CH_SLASH) begin
                    n_star = 1'b0;
                    n_mode = MODE_IDLE;
                end else begin
                    bump   = (c == CH_LF);
                    n_star = (c == CH_STAR);
                end
            end
            default: begin
                do_start = 1'b1;
            end
        endcase

        if (do_start) begin
            n_mode = st.mode;
            n_kw   = st.kw;
            bump   = st.bump;
            if (st.halt) begin
                n_halt = 1'b1;
            end
        end

        n_line = (bump && r_line != LINE_MAX) ? r_line + LINE_ONE : r_line;

        o_push.valid            = fire && (pre_emit || (do_start && st.emit));
        o_push.entry.two        = pre_emit && do_start && st.emit;
        o_push.entry.res0       = pre_emit ? pre_res : st.res;
        o_push.entry.res1       = st.res;
        o_push.entry.line       = LINE_NUM_W'(r_line);
    end

endmodule

`default_nettype wire

@@ sv/cts_queue.sv @@
// short queue of result entries between front and back
`default_nettype none

module cts_queue #(
    parameter int DEPTH = cts_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire cts_pkg::t_push i_push,
    input  wire                 i_pop,
    output logic                o_full,
    output cts_pkg::t_head      o_head
);
    import cts_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full       = (r_cnt == CNT_FULL);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.entry = r_mem[r_rd];

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_ONE;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

endmodule

`default_nettype wire

@@ sv/cts_back.sv @@
// back end: output register that hands out the results of each entry one beat at a time
`default_nettype none

module cts_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire cts_pkg::t_head i_head,
    output logic                o_pop,
    cts_out_if.source           o_out
);
    import cts_pkg::*;

    logic    r_valid;
    logic    r_sel;
    t_entry  r_ent;
    logic    take, last_cur, free;
    t_result cur;

    assign take     = r_valid && o_out.ready;
    assign last_cur = r_sel || !r_ent.two;
    assign free     = !r_valid || (take && last_cur);
    assign o_pop    = free && i_head.valid;

    assign cur               = r_sel ? r_ent.res1 : r_ent.res0;
    assign o_out.valid       = r_valid;
    assign o_out.token_kind  = cur.kind;
    assign o_out.error_code  = cur.err;
    assign o_out.token_line  = r_ent.line;
    assign o_out.last_of_run = last_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
            r_sel   <= 1'b0;
        end else if (free) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (take) begin
            r_sel   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_head.entry;
        end
    end

endmodule

`default_nettype wire

@@ sv/calculator_token_scanner.sv @@
// top level of the calculator token scanner
//
//  channel   dir   beat payload
//  i_in      in    char_code[7:0], end_of_input
//  o_out     out   token_kind[3:0], token_line[15:0], error_code[1:0], last_of_run
//
// one character beat per cycle enters the scan state machine in the front end while the queue is not full
// each character beat makes zero, one or two token beats; two-token entries are handed out
// one token beat at a time, so the sustained rate is one character per cycle until the queue fills
// reset is synchronous, with no clearing pass
// the front stalls only when the queue is full; the output register stalls on o_out.ready
// after an error beat every character beat is taken and dropped until reset
`default_nettype none

module calculator_token_scanner #(
    parameter int LINE_BITS   = cts_pkg::LINE_BITS_DEF,
    parameter int QUEUE_DEPTH = cts_pkg::QUEUE_DEPTH_DEF
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    cts_in_if.sink    i_in,
    cts_out_if.source o_out
);
    import cts_pkg::*;

    t_push push;
    t_head head;
    logic  q_full;
    logic  pop;

    cts_front #(
        .LINE_BITS(LINE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push)
    );

    cts_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    cts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

@@ sv/cts_checker.sv @@
// port-level checks of the token scanner and their binding
`default_nettype none
`include "calculator_token_scanner_macros.svh"

module cts_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [3:0] i_token_kind,
    input wire [1:0] i_error_code,
    input wire       i_last_of_run
);
    import cts_pkg::*;

    logic err_beat;

    assign err_beat = i_out_valid && (i_error_code != ERR_NONE);

    // stalled beat stays offered
    `CTS_ASSERT_NXT(a_hold_valid, i_out_valid && !i_out_ready, i_out_valid)

    // an error beat ends its run and carries no token
    `CTS_ASSERT_IMP(a_err_last, err_beat, i_last_of_run && i_token_kind == KIND_ID)

    // eof always ends its run
    `CTS_ASSERT_IMP(a_eof_last, i_out_valid && i_token_kind == KIND_EOF, i_last_of_run)

    // nothing follows a taken error beat
    `CTS_ASSERT_NXT(a_halt_quiet, err_beat && i_out_ready, !i_out_valid)

endmodule

bind calculator_token_scanner cts_checker u_cts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_token_kind  (o_out.token_kind),
    .i_error_code  (o_out.error_code),
    .i_last_of_run (o_out.last_of_run)
);

`default_nettype wire

@@ tb/tb_calculator_token_scanner.sv @@
// testbench: drives directed and random character streams and checks every token beat
`default_nettype none

module tb_calculator_token_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    import cts_pkg::*;

    localparam int          CLK_PERIOD   = 10;
    localparam int unsigned CYCLE_LIMIT  = 500_000;
    localparam int unsigned PHASE_ITEMS  = 130;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          DRAIN_CYCLES = 32;
    localparam int          BLANK_LINES  = 100;
    localparam int          LINE_W       = LINE_BITS_DEF;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [LINE_NUM_W-1:0] line_no;
        logic [ERR_W-1:0]      err;
        logic                  last;
    } t_scan_token;

    class t_token_checker;
        t_mode             mode;
        logic [KW_W-1:0]   kw;
        logic [LINE_W-1:0] line_cnt;
        bit                star_seen;
        bit                halted;
        t_scan_token       step_tok[2];
        int                n_step;
        t_scan_token       tokens_due[$];
        int unsigned       errors;

        function new();
            mode      = MODE_IDLE;
            kw        = KW_NONE;
            line_cnt  = LINE_W'(1);
            star_seen = 1'b0;
            halted    = 1'b0;
            errors    = 0;
        endfunction

        function bit is_alpha(logic [CHAR_W-1:0] c);
            return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
        endfunction

        function bit is_digit(logic [CHAR_W-1:0] c);
            return c >= CH_0 && c <= CH_9;
        endfunction

        function bit is_space(logic [CHAR_W-1:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit starts_token(logic [CHAR_W-1:0] c);
            return is_space(c) || is_alpha(c) || is_digit(c) || c == CH_COLON
                || c == CH_SLASH || c == CH_PLUS || c == CH_MINUS || c == CH_STAR
                || c == CH_LPAREN || c == CH_RPAREN;
        endfunction

        function void bump_line();
            if (line_cnt != '1) begin
                line_cnt = line_cnt + 1'b1;
            end
        endfunction

        function void add_token(logic [KIND_W-1:0] kind, logic [ERR_W-1:0] err);
            step_tok[n_step] = '{kind: kind, line_no: line_cnt[LINE_NUM_W-1:0],
                                 err: err, last: 1'b0};
            n_step++;
        endfunction

        function void halt_scan(logic [ERR_W-1:0] err);
            add_token(KIND_ID, err);
            halted = 1'b1;
            mode   = MODE_IDLE;
        endfunction

        function logic [KW_W-1:0] kw_advance(logic [CHAR_W-1:0] c);
            case (kw)
                KW_R1:   return (c == CH_LO_E) ? KW_R2 : KW_NONE;
                KW_R2:   return (c == CH_LO_A) ? KW_R3 : KW_NONE;
                KW_R3:   return (c == CH_LO_D) ? KW_READ : KW_NONE;
                KW_W1:   return (c == CH_LO_R) ? KW_W2 : KW_NONE;
                KW_W2:   return (c == CH_LO_I) ? KW_W3 : KW_NONE;
                KW_W3:   return (c == CH_LO_T) ? KW_W4 : KW_NONE;
                KW_W4:   return (c == CH_LO_E) ? KW_WRITE : KW_NONE;
                default: return KW_NONE;
            endcase
        endfunction

        // character seen between tokens
        function void begin_token(logic [CHAR_W-1:0] c, logic eoi);
            mode = MODE_IDLE;
            if (eoi) begin
                add_token(KIND_EOF, ERR_NONE);
            end else if (is_space(c)) begin
                if (c == CH_LF) begin
                    bump_line();
                end
            end else if (is_alpha(c)) begin
                mode = MODE_IDENT;
                kw   = (c == CH_LO_R) ? KW_R1 : (c == CH_LO_W) ? KW_W1 : KW_NONE;
            end else if (is_digit(c)) begin
                mode = MODE_NUMBER;
            end else begin
                case (c)
                    CH_COLON:  mode = MODE_COLON;
                    CH_SLASH:  mode = MODE_SLASH;
                    CH_PLUS:   add_token(KIND_ADD, ERR_NONE);
                    CH_MINUS:  add_token(KIND_SUB, ERR_NONE);
                    CH_STAR:   add_token(KIND_MUL, ERR_NONE);
                    CH_LPAREN: add_token(KIND_LPAREN, ERR_NONE);
                    CH_RPAREN: add_token(KIND_RPAREN, ERR_NONE);
                    default:   halt_scan(ERR_BAD_CHAR);
                endcase
            end
        endfunction

        function void scan_char(logic [CHAR_W-1:0] c, logic eoi);
            int i;
            if (halted) begin
                return;
            end
            n_step = 0;
            case (mode)
                MODE_IDENT: begin
                    if (!eoi && (is_alpha(c) || is_digit(c) || c == CH_UNDER)) begin
                        kw = kw_advance(c);
                    end else begin
                        add_token(kw == KW_READ ? KIND_READ :
                                  kw == KW_WRITE ? KIND_WRITE : KIND_ID, ERR_NONE);
                        kw = KW_NONE;
                        begin_token(c, eoi);
                    end
                end
                MODE_NUMBER: begin
                    if (eoi || !is_digit(c)) begin
                        add_token(KIND_LIT, ERR_NONE);
                        begin_token(c, eoi);
                    end
                end
                MODE_COLON: begin
                    if (!eoi && c == CH_EQUAL) begin
                        add_token(KIND_BECOMES, ERR_NONE);
                        mode = MODE_IDLE;
                    end else begin
                        halt_scan(ERR_BAD_ASSIGN);
                    end
                end
                MODE_SLASH: begin
                    if (!eoi && c == CH_SLASH) begin
                        mode = MODE_LINEC;
                    end else if (!eoi && c == CH_STAR) begin
                        mode      = MODE_BLOCKC;
                        star_seen = 1'b0;
                    end else begin
                        add_token(KIND_DIV, ERR_NONE);
                        begin_token(c, eoi);
                    end
                end
                MODE_LINEC: begin
                    if (eoi || c == CH_LF) begin
                        begin_token(c, eoi);
                    end
                end
                MODE_BLOCKC: begin
                    if (eoi) begin
                        halt_scan(ERR_OPEN_CMT);
                    end else if (star_seen && c == CH_SLASH) begin
                        star_seen = 1'b0;
                        mode      = MODE_IDLE;
                    end else begin
                        if (c == CH_LF) begin
                            bump_line();
                        end
                        star_seen = (c == CH_STAR);
                    end
                end
                default: begin_token(c, eoi);
            endcase
            if (n_step > 0) begin
                step_tok[n_step-1].last = 1'b1;
            end
            for (i = 0; i < n_step; i++) begin
                tokens_due.push_back(step_tok[i]);
            end
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void match_token(logic [KIND_W-1:0] kind, logic [LINE_NUM_W-1:0] line_no,
                                  logic [ERR_W-1:0] err, logic last);
            t_scan_token want;
            if (tokens_due.size() == 0) begin
                note_error($sformatf("unexpected token: kind %0d line %0d err %0d last %0d",
                                     kind, line_no, err, last));
                return;
            end
            want = tokens_due.pop_front();
            if (want.kind !== kind || want.line_no !== line_no || want.err !== err
                    || want.last !== last) begin
                note_error($sformatf({"token mismatch: kind %0d/%0d line %0d/%0d",
                                      " err %0d/%0d last %0d/%0d (expected/actual)"},
                                     want.kind, kind, want.line_no, line_no,
                                     want.err, err, want.last, last));
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cts_in_if  in_if ();
    cts_out_if out_if ();

    calculator_token_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_token_checker chk = new();

    bit          fast_tx  = 1'b0;
    bit          fast_rx  = 1'b0;
    bit          hold_req = 1'b0;
    bit          div_open = 1'b0;
    int unsigned items_sent = 0;
    int unsigned cycles     = 0;

    string ident_words[10] = '{"read", "write", "read", "write", "rea", "writ",
                               "reads", "write_9", "Read", "wrote"};

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("calculator_token_scanner regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                chk.scan_char(in_if.char_code, in_if.end_of_input);
            end
            if (out_if.valid && out_if.ready) begin
                chk.match_token(out_if.token_kind, out_if.token_line, out_if.error_code,
                                out_if.last_of_run);
            end
        end
    end

    // token sink with random stalls and one long hold-off
    initial begin
        int stall;
        out_if.ready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if ($urandom_range(0, 39) == 0) begin
                    fast_rx = ($urandom_range(0, 2) == 0);
                end
                stall = fast_rx ? 0 : $urandom_range(0, 3);
                if (stall > 0) begin
                    out_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
        end
    end

    function automatic logic [CHAR_W-1:0] rand_byte();
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [CHAR_W-1:0] rand_letter();
        return CHAR_W'(($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + $urandom_range(0, 25));
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic eoi);
        int gap;
        gap = fast_tx ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.char_code    <= c;
        in_if.end_of_input <= eoi;
        do @(posedge i_clk); while (!in_if.ready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_char(CHAR_W'(s[i]), 1'b0);
        end
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (chk.tokens_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_token();
        int                pick;
        int                len;
        int                r;
        logic [CHAR_W-1:0] c;
        logic [CHAR_W-1:0] prev;
        pick = $urandom_range(0, 99);
        // keep a pending divide from merging into a comment opener
        if (div_open && ((pick >= 59 && pick <= 64) || (pick >= 80 && pick <= 92))) begin
            send_char(CH_SPACE, 1'b0);
        end
        if (pick < 8) begin
            send_text(ident_words[$urandom_range(0, 9)]);
        end else if (pick < 25) begin
            send_char(rand_letter(), 1'b0);
            len = $urandom_range(0, 5);
            repeat (len) begin
                r = $urandom_range(0, 9);
                c = (r < 6) ? rand_letter() :
                    (r < 9) ? CHAR_W'(CH_0 + $urandom_range(0, 9)) : CH_UNDER;
                send_char(c, 1'b0);
            end
        end else if (pick < 38) begin
            len = $urandom_range(1, 4);
            repeat (len) send_char(CHAR_W'(CH_0 + $urandom_range(0, 9)), 1'b0);
        end else if (pick < 43) begin
            send_char(CH_COLON, 1'b0);
            send_char(CH_EQUAL, 1'b0);
        end else if (pick < 48) begin
            send_char(CH_LPAREN, 1'b0);
        end else if (pick < 53) begin
            send_char(CH_RPAREN, 1'b0);
        end else if (pick < 56) begin
            send_char(CH_PLUS, 1'b0);
        end else if (pick < 59) begin
            send_char(CH_MINUS, 1'b0);
        end else if (pick < 62) begin
            send_char(CH_STAR, 1'b0);
        end else if (pick < 65) begin
            send_char(CH_SLASH, 1'b0);
        end else if (pick < 80) begin
            len = $urandom_range(1, 3);
            repeat (len) begin
                r = $urandom_range(0, 5);
                send_char((r == 0) ? CH_SPACE : CHAR_W'(CH_TAB + r - 1), 1'b0);
            end
        end else if (pick < 86) begin
            send_char(CH_SLASH, 1'b0);
            send_char(CH_SLASH, 1'b0);
            len = $urandom_range(0, 6);
            repeat (len) begin
                do c = rand_byte(); while (c == CH_LF);
                send_char(c, 1'b0);
            end
            if ($urandom_range(0, 4) == 0) begin
                send_char(rand_byte(), 1'b1);
            end else begin
                send_char(CH_LF, 1'b0);
            end
        end else if (pick < 93) begin
            send_char(CH_SLASH, 1'b0);
            send_char(CH_STAR, 1'b0);
            prev = CH_SPACE;
            len  = $urandom_range(0, 6);
            repeat (len) begin
                r = $urandom_range(0, 9);
                c = (r < 3) ? CH_STAR : (r == 3) ? CH_LF : (r == 4) ? CH_SLASH : rand_byte();
                if (prev == CH_STAR && c == CH_SLASH) begin
                    c = CH_SPACE;
                end
                send_char(c, 1'b0);
                prev = c;
            end
            send_char(CH_STAR, 1'b0);
            send_char(CH_SLASH, 1'b0);
        end else begin
            send_char(rand_byte(), 1'b1);
        end
        div_open = (pick >= 62 && pick < 65);
    endtask

    initial begin
        int unsigned       target;
        int                phase;
        logic [ERR_W-1:0]  err_pick;
        logic [CHAR_W-1:0] c;

        in_if.valid        = 1'b0;
        in_if.char_code    = '0;
        in_if.end_of_input = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every token kind but eof, keyword near misses, lookahead closing two tokens
        send_text("read writ write:=(7)+-*/a\n");
        // star of the opener does not close, newline inside counted, byte extremes
        send_text("/*/");
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("\n*/");
        // line comment closed by end of input, then a fresh stream
        send_text("//q");
        send_char(CH_SPACE, 1'b1);
        send_char(8'hFF, 1'b1);
        wait_drained();

        target = items_sent;
        for (phase = 0; phase < 6; phase++) begin
            target += PHASE_ITEMS;
            while (items_sent < target) begin
                if ($urandom_range(0, 29) == 0) begin
                    fast_tx = ($urandom_range(0, 2) == 0);
                end
                send_random_token();
            end
            if (phase == 2) begin
                // sink holds off while operators keep coming
                hold_req = 1'b1;
                fast_tx  = 1'b1;
                repeat (40) send_char(CH_PLUS, 1'b0);
                div_open = 1'b0;
            end
            fast_tx = 1'b0;
            wait_drained();
        end

        // long run of blank lines with no gaps
        fast_tx = 1'b1;
        repeat (BLANK_LINES) send_char(CH_LF, 1'b0);
        fast_tx  = 1'b0;
        div_open = 1'b0;
        repeat (40) send_random_token();
        wait_drained();

        // one error at the end, then the block must stay silent
        send_char(rand_byte(), 1'b1);
        if ($urandom_range(0, 1)) begin
            send_text("ab");
        end
        err_pick = ERR_W'($urandom_range(1, 3));
        case (err_pick)
            ERR_BAD_ASSIGN: begin
                send_char(CH_COLON, 1'b0);
                if ($urandom_range(0, 1)) begin
                    send_char(rand_byte(), 1'b1);
                end else begin
                    do c = rand_byte(); while (c == CH_EQUAL);
                    send_char(c, 1'b0);
                end
            end
            ERR_OPEN_CMT: begin
                send_text("/*");
                repeat ($urandom_range(0, 4)) send_char(CH_LF, 1'b0);
                send_char(rand_byte(), 1'b1);
            end
            default: begin
                do c = rand_byte(); while (chk.starts_token(c));
                send_char(c, 1'b0);
            end
        endcase
        repeat (24) send_char(rand_byte(), $urandom_range(0, 3) == 0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (chk.errors == 0) begin
            $display("calculator_token_scanner regression: pass");
        end else begin
            $display("calculator_token_scanner regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
